// ----- rtl/sidad_pkg.sv -----
// sidad_pkg: shared constants and types for the signed integer to decimal
// ASCII converter. No dependencies.
`default_nettype none

package sidad_pkg;

    // Default width of the signed input value
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int CHAR_WIDTH = 8;

    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 8'h2D;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/sidad_if.sv -----
// sidad_num_if / sidad_text_if: valid-ready channels for the input value and
// the output characters. Depends on sidad_pkg.
`default_nettype none

interface sidad_num_if #(
    parameter int VALUE_WIDTH = sidad_pkg::VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sidad_text_if;
    logic                              valid;
    logic                              ready;
    logic [sidad_pkg::CHAR_WIDTH-1:0]  character;
    logic                              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/sidad_dabble_step.sv -----
// sidad_dabble_step: one shift-and-add-3 step of the binary to BCD converter.
// Standalone; no package use.
`default_nettype none

module sidad_dabble_step #(
    parameter int VALUE_WIDTH = 32,
    parameter int DIGITS      = 10
) (
    input  wire logic [4*DIGITS-1:0]  bcd,
    input  wire logic [VALUE_WIDTH-1:0] bin,
    output logic      [4*DIGITS-1:0]  bcd_out,
    output logic      [VALUE_WIDTH-1:0] bin_out
);

    logic [4*DIGITS-1:0] adj;

    // Each BCD digit of 5 or more gets 3 added before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
            else
            begin
                adj[4*i +: 4] = bcd[4*i +: 4];
            end
        end
    end

    assign bcd_out = {adj[4*DIGITS-2:0], bin[VALUE_WIDTH-1]};
    assign bin_out = {bin[VALUE_WIDTH-2:0], 1'b0};

endmodule

`default_nettype wire

// ----- rtl/signed_int_to_decimal_ascii_unit.sv -----
// signed_int_to_decimal_ascii_unit: top level of the integer to decimal text
// converter. Depends on sidad_pkg, sidad_if.sv and sidad_dabble_step.
//
//  Channel | Modport | Payload                       | Transfer
//  --------+---------+-------------------------------+-----------------------
//  num     | sink    | value  (VALUE_WIDTH, signed)  | one integer
//  text    | source  | character (8), last (1)       | one ASCII character
//
// Sequence: the value is taken, VALUE_WIDTH shift-add-3 steps run in the shared
// dabble unit, then the sign (if negative) and each BCD digit position are
// emitted in turn, with leading zeros stepped over.
// num.ready is high only in the idle state; the final character may still
// sit in the output register while the next value is taken.
// A stall on text holds the output register; the emit sequence waits at the
// next character to show (leading zeros are still stepped over).
// Reset (rst_n, asynchronous) clears the sequencer and the output valid flag.
`default_nettype none

module signed_int_to_decimal_ascii_unit #(
    parameter int VALUE_WIDTH = sidad_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    sidad_num_if.sink       num,
    sidad_text_if.source    text
);

    // Decimal digits enough for any VALUE_WIDTH-bit magnitude
    localparam int DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W  = 4 * DIGITS;
    localparam int CNT_W  = $clog2(VALUE_WIDTH);
    localparam int LEFT_W = $clog2(DIGITS + 1);

    sidad_pkg::state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [LEFT_W-1:0]      left_reg, left_next;
    logic                   neg_reg, neg_next;
    logic                   sign_pend_reg, sign_pend_next;
    logic                   started_reg, started_next;

    logic                             out_valid_reg, out_valid_next;
    logic [sidad_pkg::CHAR_WIDTH-1:0] char_reg, char_next;
    logic                             last_reg, last_next;

    logic [VALUE_WIDTH-1:0] mag;
    logic [BCD_W-1:0]       step_bcd;
    logic [VALUE_WIDTH-1:0] step_bin;
    logic [3:0]             top_digit;
    logic                   last_digit;
    logic                   slot_free;
    logic                   load;

    // Magnitude; the most negative value wraps to its true unsigned size
    assign mag = num.value[VALUE_WIDTH-1] ?
                 (VALUE_WIDTH'(0) - $unsigned(num.value)) : $unsigned(num.value);

    sidad_dabble_step #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIGITS      (DIGITS)
    ) u_step (
        .bcd     (bcd_reg),
        .bin     (bin_reg),
        .bcd_out (step_bcd),
        .bin_out (step_bin)
    );

    assign top_digit  = bcd_reg[BCD_W-1 -: 4];
    assign last_digit = (left_reg == LEFT_W'(1));
    assign slot_free  = !out_valid_reg || text.ready;

    assign num.ready      = (state_reg == sidad_pkg::ST_IDLE);
    assign text.valid     = out_valid_reg;
    assign text.character = char_reg;
    assign text.last      = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        left_next      = left_reg;
        neg_next       = neg_reg;
        sign_pend_next = sign_pend_reg;
        started_next   = started_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        load           = 1'b0;

        case (state_reg)
            sidad_pkg::ST_IDLE:
            begin
                if (num.valid)
                begin
                    bin_next       = mag;
                    bcd_next       = '0;
                    cnt_next       = '0;
                    left_next      = LEFT_W'(DIGITS);
                    neg_next       = num.value[VALUE_WIDTH-1];
                    sign_pend_next = num.value[VALUE_WIDTH-1];
                    started_next   = 1'b0;
                    state_next     = sidad_pkg::ST_CONV;
                end
            end
            sidad_pkg::ST_CONV:
            begin
                bin_next = step_bin;
                bcd_next = step_bcd;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VALUE_WIDTH - 1))
                begin
                    state_next = sidad_pkg::ST_EMIT;
                end
            end
            sidad_pkg::ST_EMIT:
            begin
                if (sign_pend_reg)
                begin
                    if (slot_free)
                    begin
                        load           = 1'b1;
                        char_next      = sidad_pkg::ASCII_MINUS;
                        last_next      = 1'b0;
                        sign_pend_next = 1'b0;
                    end
                end
                else if (top_digit == 4'd0 && !started_reg && !last_digit)
                begin
                    // leading zero: step over it
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    left_next = left_reg - LEFT_W'(1);
                end
                else if (slot_free)
                begin
                    load         = 1'b1;
                    char_next    = sidad_pkg::ASCII_ZERO + {4'd0, top_digit};
                    last_next    = last_digit;
                    bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                    left_next    = left_reg - LEFT_W'(1);
                    started_next = 1'b1;
                    if (last_digit)
                    begin
                        state_next = sidad_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sidad_pkg::ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (text.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sidad_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            sign_pend_reg <= 1'b0;
            neg_reg       <= 1'b0;
            started_reg   <= 1'b0;
            cnt_reg       <= '0;
            left_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sign_pend_reg <= sign_pend_next;
            neg_reg       <= neg_next;
            started_reg   <= started_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    // A pending sign belongs only to a negative value
    a_sign_neg: assert property (@(posedge clk) disable iff (!rst_n)
        sign_pend_reg |-> neg_reg)
        else $error("sign pending for non-negative value");

    // Emit never runs out of digit positions
    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sidad_pkg::ST_EMIT) |-> (left_reg != '0))
        else $error("emit with no digits left");

    // Shown character is a decimal digit or the minus sign
    a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((char_reg >= sidad_pkg::ASCII_ZERO &&
                            char_reg <= sidad_pkg::ASCII_ZERO + 8'd9) ||
                           char_reg == sidad_pkg::ASCII_MINUS))
        else $error("bad character code");

    // The minus sign never ends a number
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && char_reg == sidad_pkg::ASCII_MINUS) |-> !last_reg)
        else $error("minus sign marked last");

    // A held result stays put while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !text.ready) |=> (out_valid_reg && $stable(char_reg)))
        else $error("stalled character changed");

endmodule

`default_nettype wire
